FILE: rtl/epcal_pkg.sv
`default_nettype none

package epcal_pkg;

   localparam int unsigned SecsPerDay         = 86400;
   localparam int unsigned SecsPerHour        = 3600;
   localparam int unsigned SecsPerMin         = 60;
   localparam int unsigned EpochYear          = 1970;
   localparam int unsigned EpochWeekdayOffset = 4;
   localparam int unsigned DaysPerWeek        = 7;
   localparam int unsigned DaysPerYear        = 365;
   localparam int unsigned DaysPerLeapYear    = 366;
   localparam int unsigned LeapCycle          = 4;
   localparam int unsigned CenturyYears       = 100;
   localparam int unsigned LeapCenturyCycle   = 400;
   localparam int unsigned MonthsPerYear      = 12;
   localparam int unsigned MarchIndex         = 2;

   // Reciprocals for division by constants. Each is rounded down, so the
   // estimate is the true quotient or one below it.
   // 86400 = 128 * 675: the day split divides secs >> 7 by 675.
   localparam int unsigned DayPreShift    = 7;
   localparam int unsigned RecipDay       = 101806632;
   localparam int unsigned RecipDayShift  = 36;
   localparam int unsigned RecipHour      = 1165;
   localparam int unsigned RecipHourShift = 22;
   localparam int unsigned RecipMin       = 1092;
   localparam int unsigned RecipMinShift  = 16;
   localparam int unsigned RecipWeek      = 74898;
   localparam int unsigned RecipWeekShift = 19;

   localparam int unsigned YearIndexBits = 8;
   localparam int unsigned YearEntries   = 1 << YearIndexBits;

   typedef logic [16:0] year_start_table_type [YearEntries];
   typedef logic [YearEntries-1:0] leap_bits_type;
   typedef logic [8:0] month_start_table_type [MonthsPerYear];
   typedef logic [4:0] month_days_table_type [MonthsPerYear];

   localparam month_days_table_type MonthDays = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   function automatic logic is_leap(input int unsigned y);
      return ((y % LeapCycle == 0) && (y % CenturyYears != 0)) || (y % LeapCenturyCycle == 0);
   endfunction

   // Day number of January 1st for each year counted from the epoch year.
   function automatic year_start_table_type build_year_starts();
      year_start_table_type t;
      int unsigned acc;
      acc = 0;
      for (int unsigned i = 0; i < YearEntries; i++) begin
         t[i] = 17'(acc);
         acc  = acc + (is_leap(EpochYear + i) ? DaysPerLeapYear : DaysPerYear);
      end
      return t;
   endfunction

   function automatic leap_bits_type build_leap_bits();
      leap_bits_type b;
      for (int unsigned i = 0; i < YearEntries; i++) begin
         b[i] = is_leap(EpochYear + i);
      end
      return b;
   endfunction

   // Day of year on which each month starts in a common year.
   function automatic month_start_table_type build_month_starts();
      month_start_table_type t;
      int unsigned acc;
      acc = 0;
      for (int unsigned i = 0; i < MonthsPerYear; i++) begin
         t[i] = 9'(acc);
         acc  = acc + MonthDays[i];
      end
      return t;
   endfunction

   localparam year_start_table_type  YearStart  = build_year_starts();
   localparam leap_bits_type         LeapBits   = build_leap_bits();
   localparam month_start_table_type MonthStart = build_month_starts();

   typedef struct packed {
      logic        valid;
      logic [15:0] days;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
   } epcal_days_beat_type;

   typedef struct packed {
      logic        valid;
      logic [11:0] year;
      logic        leap;
      logic [8:0]  day_of_year;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
   } epcal_year_beat_type;

   typedef struct packed {
      logic        valid;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
   } epcal_date_beat_type;

endpackage

`default_nettype wire

FILE: rtl/epcal_req_if.sv
`default_nettype none

interface epcal_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink (input valid, input epoch_seconds, output ready);
endinterface

`default_nettype wire

FILE: rtl/epcal_rsp_if.sv
`default_nettype none

interface epcal_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] year;
   logic [3:0]  month;
   logic [4:0]  day_of_month;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;
   logic [2:0]  weekday;

   modport source (
      output valid, output year, output month, output day_of_month,
      output hour, output minute, output second, output weekday,
      input ready
   );
   modport sink (
      input valid, input year, input month, input day_of_month,
      input hour, input minute, input second, input weekday,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/epcal_daysplit.sv
`default_nettype none

module epcal_daysplit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic                       in_valid,
   input  wire logic [31:0]                in_secs,
   output epcal_pkg::epcal_days_beat_type  out_beat
);
   import epcal_pkg::*;

   // Stage A: day quotient estimate.
   logic [51:0] a_prod;
   logic [15:0] a_q_in;
   logic        a_valid_ff;
   logic [31:0] a_secs_ff;
   logic [15:0] a_q_ff;

   // Stage B: remainder against the estimate.
   logic [32:0] b_prod;
   logic [32:0] b_diff;
   logic [17:0] b_rem_in;
   logic        b_valid_ff;
   logic [15:0] b_q_ff;
   logic [17:0] b_rem_ff;

   // Stage C: corrected day count and second of day.
   logic [15:0] c_days_in;
   logic [16:0] c_rem_in;
   logic        c_valid_ff;
   logic [15:0] c_days_ff;
   logic [16:0] c_rem_ff;

   // Stage D: hour and weekday estimates.
   logic [27:0] d_hprod;
   logic [16:0] d_warg_in;
   logic [33:0] d_wprod;
   logic [4:0]  d_hest_in;
   logic [12:0] d_west_in;
   logic        d_valid_ff;
   logic [15:0] d_days_ff;
   logic [16:0] d_rem_ff;
   logic [4:0]  d_hest_ff;
   logic [16:0] d_warg_ff;
   logic [12:0] d_west_ff;

   // Stage E: remainders for hour and weekday.
   logic [16:0] e_hdiff;
   logic [16:0] e_wdiff;
   logic [12:0] e_hrem_in;
   logic [3:0]  e_wrem_in;
   logic        e_valid_ff;
   logic [15:0] e_days_ff;
   logic [4:0]  e_hest_ff;
   logic [12:0] e_hrem_ff;
   logic [3:0]  e_wrem_ff;

   // Stage F: corrected hour, weekday and second of hour.
   logic [4:0]  f_hour_in;
   logic [11:0] f_rs_in;
   logic [2:0]  f_weekday_in;
   logic        f_valid_ff;
   logic [15:0] f_days_ff;
   logic [4:0]  f_hour_ff;
   logic [11:0] f_rs_ff;
   logic [2:0]  f_weekday_ff;

   // Stage G: minute estimate.
   logic [22:0] g_prod;
   logic [5:0]  g_mest_in;
   logic        g_valid_ff;
   logic [15:0] g_days_ff;
   logic [4:0]  g_hour_ff;
   logic [11:0] g_rs_ff;
   logic [2:0]  g_weekday_ff;
   logic [5:0]  g_mest_ff;

   // Stage H: remainder within the minute.
   logic [11:0] h_diff;
   logic [6:0]  h_mrem_in;
   logic        h_valid_ff;
   logic [15:0] h_days_ff;
   logic [4:0]  h_hour_ff;
   logic [2:0]  h_weekday_ff;
   logic [5:0]  h_mest_ff;
   logic [6:0]  h_mrem_ff;

   // Stage I: corrected minute and second.
   logic [5:0]  i_minute_in;
   logic [5:0]  i_second_in;
   logic        i_valid_ff;
   logic [15:0] i_days_ff;
   logic [4:0]  i_hour_ff;
   logic [5:0]  i_minute_ff;
   logic [5:0]  i_second_ff;
   logic [2:0]  i_weekday_ff;

   always_comb begin
      a_prod = 52'(in_secs[31:DayPreShift]) * 52'(RecipDay);
      a_q_in = a_prod[RecipDayShift+15:RecipDayShift];

      b_prod   = 33'(a_q_ff) * 33'(SecsPerDay);
      b_diff   = 33'(a_secs_ff) - b_prod;
      b_rem_in = b_diff[17:0];

      if (b_rem_ff >= 18'(SecsPerDay)) begin
         c_days_in = b_q_ff + 16'd1;
         c_rem_in  = 17'(b_rem_ff - 18'(SecsPerDay));
      end else begin
         c_days_in = b_q_ff;
         c_rem_in  = b_rem_ff[16:0];
      end

      d_hprod   = 28'(c_rem_ff) * 28'(RecipHour);
      d_hest_in = d_hprod[RecipHourShift+4:RecipHourShift];
      d_warg_in = 17'(c_days_ff) + 17'(EpochWeekdayOffset);
      d_wprod   = 34'(d_warg_in) * 34'(RecipWeek);
      d_west_in = d_wprod[RecipWeekShift+12:RecipWeekShift];

      e_hdiff   = d_rem_ff - 17'(d_hest_ff) * 17'(SecsPerHour);
      e_hrem_in = e_hdiff[12:0];
      e_wdiff   = d_warg_ff - 17'(d_west_ff) * 17'(DaysPerWeek);
      e_wrem_in = e_wdiff[3:0];

      if (e_hrem_ff >= 13'(SecsPerHour)) begin
         f_hour_in = e_hest_ff + 5'd1;
         f_rs_in   = 12'(e_hrem_ff - 13'(SecsPerHour));
      end else begin
         f_hour_in = e_hest_ff;
         f_rs_in   = e_hrem_ff[11:0];
      end
      if (e_wrem_ff >= 4'(DaysPerWeek)) begin
         f_weekday_in = 3'(e_wrem_ff - 4'(DaysPerWeek));
      end else begin
         f_weekday_in = e_wrem_ff[2:0];
      end

      g_prod    = 23'(f_rs_ff) * 23'(RecipMin);
      g_mest_in = g_prod[RecipMinShift+5:RecipMinShift];

      h_diff    = g_rs_ff - 12'(g_mest_ff) * 12'(SecsPerMin);
      h_mrem_in = h_diff[6:0];

      if (h_mrem_ff >= 7'(SecsPerMin)) begin
         i_minute_in = h_mest_ff + 6'd1;
         i_second_in = 6'(h_mrem_ff - 7'(SecsPerMin));
      end else begin
         i_minute_in = h_mest_ff;
         i_second_in = h_mrem_ff[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
         h_valid_ff <= g_valid_ff;
         i_valid_ff <= h_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_secs_ff    <= in_secs;
         a_q_ff       <= a_q_in;
         b_q_ff       <= a_q_ff;
         b_rem_ff     <= b_rem_in;
         c_days_ff    <= c_days_in;
         c_rem_ff     <= c_rem_in;
         d_days_ff    <= c_days_ff;
         d_rem_ff     <= c_rem_ff;
         d_hest_ff    <= d_hest_in;
         d_warg_ff    <= d_warg_in;
         d_west_ff    <= d_west_in;
         e_days_ff    <= d_days_ff;
         e_hest_ff    <= d_hest_ff;
         e_hrem_ff    <= e_hrem_in;
         e_wrem_ff    <= e_wrem_in;
         f_days_ff    <= e_days_ff;
         f_hour_ff    <= f_hour_in;
         f_rs_ff      <= f_rs_in;
         f_weekday_ff <= f_weekday_in;
         g_days_ff    <= f_days_ff;
         g_hour_ff    <= f_hour_ff;
         g_rs_ff      <= f_rs_ff;
         g_weekday_ff <= f_weekday_ff;
         g_mest_ff    <= g_mest_in;
         h_days_ff    <= g_days_ff;
         h_hour_ff    <= g_hour_ff;
         h_weekday_ff <= g_weekday_ff;
         h_mest_ff    <= g_mest_ff;
         h_mrem_ff    <= h_mrem_in;
         i_days_ff    <= h_days_ff;
         i_hour_ff    <= h_hour_ff;
         i_minute_ff  <= i_minute_in;
         i_second_ff  <= i_second_in;
         i_weekday_ff <= h_weekday_ff;
      end
   end

   assign out_beat.valid   = i_valid_ff;
   assign out_beat.days    = i_days_ff;
   assign out_beat.hour    = i_hour_ff;
   assign out_beat.minute  = i_minute_ff;
   assign out_beat.second  = i_second_ff;
   assign out_beat.weekday = i_weekday_ff;

endmodule

`default_nettype wire

FILE: rtl/epcal_yearsearch.sv
`default_nettype none

module epcal_yearsearch (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  epcal_pkg::epcal_days_beat_type  in_beat,
   output epcal_pkg::epcal_year_beat_type  out_beat
);
   import epcal_pkg::*;

   localparam int unsigned StepsPerStage = 2;
   localparam int unsigned SearchStages  = YearIndexBits / StepsPerStage;

   typedef struct packed {
      logic                     valid;
      logic [YearIndexBits-1:0] index;
      logic [15:0]              days;
      logic [4:0]               hour;
      logic [5:0]               minute;
      logic [5:0]               second;
      logic [2:0]               weekday;
   } search_type;

   search_type search_src [SearchStages];
   search_type search_in  [SearchStages];
   search_type search_ff  [SearchStages];
   search_type last_stage;

   logic [16:0] year_base;
   logic [16:0] doy_wide;
   logic        y_valid_ff;
   logic [11:0] y_year_ff;
   logic        y_leap_ff;
   logic [8:0]  y_doy_ff;
   logic [4:0]  y_hour_ff;
   logic [5:0]  y_minute_ff;
   logic [5:0]  y_second_ff;
   logic [2:0]  y_weekday_ff;

   assign search_src[0] = '{
      valid:   in_beat.valid,
      index:   '0,
      days:    in_beat.days,
      hour:    in_beat.hour,
      minute:  in_beat.minute,
      second:  in_beat.second,
      weekday: in_beat.weekday
   };

   // Binary search for the last year whose first day is not past the day
   // count, two index bits per stage from the top bit down.
   for (genvar g = 0; g < SearchStages; g++) begin : g_search
      always_comb begin
         logic [YearIndexBits-1:0] probe;
         search_in[g] = search_src[g];
         for (int s = 0; s < StepsPerStage; s++) begin
            probe = search_in[g].index
                  | (YearIndexBits'(1) << (YearIndexBits - 1 - g * StepsPerStage - s));
            if (YearStart[probe] <= {1'b0, search_in[g].days}) begin
               search_in[g].index = probe;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            search_ff[g].valid <= 1'b0;
         end else if (advance) begin
            search_ff[g].valid <= search_in[g].valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            search_ff[g].index   <= search_in[g].index;
            search_ff[g].days    <= search_in[g].days;
            search_ff[g].hour    <= search_in[g].hour;
            search_ff[g].minute  <= search_in[g].minute;
            search_ff[g].second  <= search_in[g].second;
            search_ff[g].weekday <= search_in[g].weekday;
         end
      end

      if (g + 1 < SearchStages) begin : g_link
         assign search_src[g+1] = search_ff[g];
      end
   end

   assign last_stage = search_ff[SearchStages-1];

   always_comb begin
      year_base = YearStart[last_stage.index];
      doy_wide  = {1'b0, last_stage.days} - year_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_valid_ff <= 1'b0;
      end else if (advance) begin
         y_valid_ff <= last_stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         y_year_ff    <= 12'(EpochYear) + 12'(last_stage.index);
         y_leap_ff    <= LeapBits[last_stage.index];
         y_doy_ff     <= doy_wide[8:0];
         y_hour_ff    <= last_stage.hour;
         y_minute_ff  <= last_stage.minute;
         y_second_ff  <= last_stage.second;
         y_weekday_ff <= last_stage.weekday;
      end
   end

   assign out_beat.valid       = y_valid_ff;
   assign out_beat.year        = y_year_ff;
   assign out_beat.leap        = y_leap_ff;
   assign out_beat.day_of_year = y_doy_ff;
   assign out_beat.hour        = y_hour_ff;
   assign out_beat.minute      = y_minute_ff;
   assign out_beat.second      = y_second_ff;
   assign out_beat.weekday     = y_weekday_ff;

endmodule

`default_nettype wire

FILE: rtl/epcal_monthwalk.sv
`default_nettype none

module epcal_monthwalk (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  epcal_pkg::epcal_year_beat_type  in_beat,
   output epcal_pkg::epcal_date_beat_type  out_beat
);
   import epcal_pkg::*;

   logic [3:0]  m_index_in;
   logic        m_valid_ff;
   logic [3:0]  m_index_ff;
   logic        m_leap_ff;
   logic [8:0]  m_doy_ff;
   logic [11:0] m_year_ff;
   logic [4:0]  m_hour_ff;
   logic [5:0]  m_minute_ff;
   logic [5:0]  m_second_ff;
   logic [2:0]  m_weekday_ff;

   logic [8:0]  dom_wide;
   logic        o_valid_ff;
   logic [11:0] o_year_ff;
   logic [3:0]  o_month_ff;
   logic [4:0]  o_dom_ff;
   logic [4:0]  o_hour_ff;
   logic [5:0]  o_minute_ff;
   logic [5:0]  o_second_ff;
   logic [2:0]  o_weekday_ff;

   // First day of a month, pushed back one day from March on in a leap year.
   function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
      logic [8:0] base;
      base = MonthStart[idx];
      return base + ((leap && idx >= 4'(MarchIndex)) ? 9'd1 : 9'd0);
   endfunction

   // Month starts rise with the index, so the last one not past the day wins.
   always_comb begin
      m_index_in = '0;
      for (int m = 1; m < MonthsPerYear; m++) begin
         if (month_start(4'(m), in_beat.leap) <= in_beat.day_of_year) begin
            m_index_in = 4'(m);
         end
      end
   end

   always_comb begin
      dom_wide = m_doy_ff - month_start(m_index_ff, m_leap_ff) + 9'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff <= in_beat.valid;
         o_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_index_ff   <= m_index_in;
         m_leap_ff    <= in_beat.leap;
         m_doy_ff     <= in_beat.day_of_year;
         m_year_ff    <= in_beat.year;
         m_hour_ff    <= in_beat.hour;
         m_minute_ff  <= in_beat.minute;
         m_second_ff  <= in_beat.second;
         m_weekday_ff <= in_beat.weekday;
         o_year_ff    <= m_year_ff;
         o_month_ff   <= m_index_ff + 4'd1;
         o_dom_ff     <= dom_wide[4:0];
         o_hour_ff    <= m_hour_ff;
         o_minute_ff  <= m_minute_ff;
         o_second_ff  <= m_second_ff;
         o_weekday_ff <= m_weekday_ff;
      end
   end

   assign out_beat.valid        = o_valid_ff;
   assign out_beat.year         = o_year_ff;
   assign out_beat.month        = o_month_ff;
   assign out_beat.day_of_month = o_dom_ff;
   assign out_beat.hour         = o_hour_ff;
   assign out_beat.minute       = o_minute_ff;
   assign out_beat.second       = o_second_ff;
   assign out_beat.weekday      = o_weekday_ff;

endmodule

`default_nettype wire

FILE: rtl/epoch_seconds_to_calendar_top.sv
// Seconds since 1970-01-01 00:00:00 UTC to a Gregorian calendar breakdown.
//
// The request channel carries one 32-bit unsigned seconds count per beat.
// The response channel returns one beat per request, in order, with year,
// month, day of month, hour, minute, second and weekday (0 is Sunday).
//
// From an accepted request to its response beat, nine stages split the
// count into days and time of day with reciprocal multiplies and one-step
// corrections, five stages find the year by binary search in a table of
// year start days and then the day of year, and two stages pick the month.
// Throughput is one beat per cycle while the response beat is not held.
//
// All stages advance together. While the response beat waits for ready,
// the whole pipeline holds and request ready is low, so nothing is lost or
// repeated; empty stages do not hold it up. Reset clears the valid bits.
`default_nettype none

module epoch_seconds_to_calendar_top (
   input wire logic   clock,
   input wire logic   reset,
   epcal_req_if.sink  req_chan,
   epcal_rsp_if.source rsp_chan
);
   import epcal_pkg::*;

   logic                advance;
   epcal_days_beat_type days_beat;
   epcal_year_beat_type year_beat;
   epcal_date_beat_type date_beat;

   assign advance        = !date_beat.valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   epcal_daysplit u_daysplit (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_chan.valid),
      .in_secs  (req_chan.epoch_seconds),
      .out_beat (days_beat)
   );

   epcal_yearsearch u_yearsearch (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_beat  (days_beat),
      .out_beat (year_beat)
   );

   epcal_monthwalk u_monthwalk (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_beat  (year_beat),
      .out_beat (date_beat)
   );

   assign rsp_chan.valid        = date_beat.valid;
   assign rsp_chan.year         = date_beat.year;
   assign rsp_chan.month        = date_beat.month;
   assign rsp_chan.day_of_month = date_beat.day_of_month;
   assign rsp_chan.hour         = date_beat.hour;
   assign rsp_chan.minute       = date_beat.minute;
   assign rsp_chan.second       = date_beat.second;
   assign rsp_chan.weekday      = date_beat.weekday;

endmodule

`default_nettype wire

FILE: tb/epcal_checker.sv
`timescale 1ns / 100ps

module epcal_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [31:0] req_epoch_seconds,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [11:0] rsp_year,
   input  wire logic [3:0]  rsp_month,
   input  wire logic [4:0]  rsp_day_of_month,
   input  wire logic [4:0]  rsp_hour,
   input  wire logic [5:0]  rsp_minute,
   input  wire logic [5:0]  rsp_second,
   input  wire logic [2:0]  rsp_weekday,
   output int unsigned      error_count,
   output int unsigned      pending_count
);

   localparam int unsigned DaySeconds    = 86400;
   localparam int unsigned HourSeconds   = 3600;
   localparam int unsigned MinuteSeconds = 60;
   localparam int unsigned FirstYear     = 1970;
   // January 1st 1970 fell on a Thursday.
   localparam int unsigned FirstWeekday  = 4;

   localparam int unsigned MonthLength [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
   } calendar_type;

   calendar_type expected_dates [$];
   calendar_type oldest_date;

   function automatic bit leap_year(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic calendar_type calendar_of(input logic [31:0] secs);
      calendar_type cal;
      int unsigned  days;
      int unsigned  tod;
      int unsigned  yr;
      int unsigned  mon;
      int unsigned  span;
      days = secs / DaySeconds;
      tod  = secs % DaySeconds;
      cal.hour    = 5'(tod / HourSeconds);
      cal.minute  = 6'((tod % HourSeconds) / MinuteSeconds);
      cal.second  = 6'(tod % MinuteSeconds);
      cal.weekday = 3'((days + FirstWeekday) % 7);
      yr = FirstYear;
      span = leap_year(yr) ? 366 : 365;
      while (days >= span) begin
         days = days - span;
         yr++;
         span = leap_year(yr) ? 366 : 365;
      end
      mon = 0;
      while (mon < 12) begin
         span = (mon == 1 && leap_year(yr)) ? 29 : MonthLength[mon];
         if (days < span) break;
         days = days - span;
         mon++;
      end
      cal.year         = 12'(yr);
      cal.month        = 4'(mon + 1);
      cal.day_of_month = 5'(days + 1);
      return cal;
   endfunction

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         error_count++;
      end
   endtask

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_dates.push_back(calendar_of(req_epoch_seconds));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_dates.size() == 0) begin
               $error("response beat with no request outstanding");
               error_count++;
            end else begin
               oldest_date = expected_dates.pop_front();
               compare_field("year", oldest_date.year, rsp_year);
               compare_field("month", oldest_date.month, rsp_month);
               compare_field("day_of_month", oldest_date.day_of_month, rsp_day_of_month);
               compare_field("hour", oldest_date.hour, rsp_hour);
               compare_field("minute", oldest_date.minute, rsp_minute);
               compare_field("second", oldest_date.second, rsp_second);
               compare_field("weekday", oldest_date.weekday, rsp_weekday);
            end
         end
         pending_count = expected_dates.size();
      end
   end

endmodule

FILE: tb/tb_epoch_seconds_to_calendar_top.sv
`timescale 1ns / 100ps

module tb_epoch_seconds_to_calendar_top;

   localparam int unsigned ItemsPerPhase = 534;
   localparam int unsigned DrainLimit    = 20000;
   localparam int unsigned SettleCycles  = 40;
   localparam int unsigned DaySeconds    = 86400;

   localparam int unsigned MonthLength [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   // Extremes of the range, the epoch, time-of-day rollovers, year ends,
   // February 29th in a leap year and March 1st in a century non-leap year.
   localparam logic [31:0] DirectedSeconds [24] = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd31535999, 32'd31536000, 32'd68169599, 32'd68169600, 32'd68256000,
      32'd94694399, 32'd951782400, 32'd951868800, 32'd4107542399, 32'd4107542400,
      32'd2147483647, 32'd2147483648, 32'd4294967294, 32'd4294967295,
      32'hAAAAAAAA, 32'h55555555
   };

   logic        clock = 1'b0;
   logic        reset;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned error_count;
   int unsigned pending_count;

   epcal_req_if req_chan ();
   epcal_rsp_if rsp_chan ();

   epoch_seconds_to_calendar_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   epcal_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_chan.valid),
      .req_ready         (req_chan.ready),
      .req_epoch_seconds (req_chan.epoch_seconds),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_year          (rsp_chan.year),
      .rsp_month         (rsp_chan.month),
      .rsp_day_of_month  (rsp_chan.day_of_month),
      .rsp_hour          (rsp_chan.hour),
      .rsp_minute        (rsp_chan.minute),
      .rsp_second        (rsp_chan.second),
      .rsp_weekday       (rsp_chan.weekday),
      .error_count       (error_count),
      .pending_count     (pending_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   function automatic bit leap_year(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic logic [63:0] time_of_day();
      case ($urandom_range(0, 2))
         0:       return 64'd0;
         1:       return 64'(DaySeconds - 1);
         default: return 64'($urandom_range(0, DaySeconds - 1));
      endcase
   endfunction

   // Mostly full-range values, with a good share landing on day, month and
   // year boundaries and near both ends of the range.
   function automatic logic [31:0] random_seconds();
      int unsigned kind;
      int unsigned yr;
      int unsigned mon;
      int unsigned days;
      logic [63:0] secs;
      kind = $urandom_range(0, 9);
      days = 0;
      case (kind)
         0, 1, 2, 3: secs = 64'($urandom());
         4, 5:       secs = 64'($urandom_range(0, 49709)) * DaySeconds + time_of_day();
         6, 7: begin
            yr  = $urandom_range(1970, 2105);
            mon = $urandom_range(0, 11);
            for (int unsigned y = 1970; y < yr; y++) days += leap_year(y) ? 366 : 365;
            for (int unsigned m = 0; m < mon; m++) begin
               days += (m == 1 && leap_year(yr)) ? 29 : MonthLength[m];
            end
            if (days > 0 && $urandom_range(0, 1) == 1) days--;
            secs = 64'(days) * DaySeconds + time_of_day();
         end
         8:          secs = 64'($urandom_range(0, 200000));
         default:    secs = 64'(32'hFFFFFFFF - $urandom_range(0, 3456000));
      endcase
      return secs[31:0];
   endfunction

   task automatic send_seconds(input logic [31:0] secs);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.epoch_seconds <= secs;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   initial begin
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.epoch_seconds = '0;
      rsp_chan.ready         = 1'b0;
      send_idle_pct          = 27;
      recv_idle_pct          = 45;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DirectedSeconds[i]) send_seconds(DirectedSeconds[i]);

      // Let the pipeline empty completely before the random part.
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 45 : 0;
         recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 27 : 0;
         repeat (ItemsPerPhase) send_seconds(random_seconds());
      end
      req_chan.valid <= 1'b0;

      for (int unsigned n = 0; n < DrainLimit && pending_count != 0; n++) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      if (error_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/epcal_pkg.sv
rtl/epcal_req_if.sv
rtl/epcal_rsp_if.sv
rtl/epcal_daysplit.sv
rtl/epcal_yearsearch.sv
rtl/epcal_monthwalk.sv
rtl/epoch_seconds_to_calendar_top.sv
tb/epcal_checker.sv
tb/tb_epoch_seconds_to_calendar_top.sv
